// File: rtl/rocca_pkg.sv
// Package for the Rocca-S AEAD encrypt block: types, constants, AES round function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rocca_pkg;

  localparam int NumRounds = 16;
  localparam int RndCntW   = 5;

  localparam logic [2:0] CfgKey0Hi  = 3'd0;
  localparam logic [2:0] CfgKey0Lo  = 3'd1;
  localparam logic [2:0] CfgKey1Hi  = 3'd2;
  localparam logic [2:0] CfgKey1Lo  = 3'd3;
  localparam logic [2:0] CfgNonceHi = 3'd4;
  localparam logic [2:0] CfgNonceLo = 3'd5;
  localparam logic [2:0] NumCfgRegs = 3'd6;

  localparam logic [127:0] Z0 = 128'hcd65ef2391443771_22ae28d7982f8a42;
  localparam logic [127:0] Z1 = 128'hbcdb8981a5dbb5e9_2f3b4deccffbc0b5;
  localparam logic [7:0] GfReduce = 8'h1b;
  localparam logic [7:0] TopBit   = 8'h80;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_AD   = 2'd1,
    CMD_MSG  = 2'd2,
    CMD_FIN  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_CIPHER = 2'd1,
    KIND_TAG    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_LOAD,
    ST_ROUNDS,
    ST_KEY_MIX,
    ST_SINGLE,
    ST_OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    RND_Z,
    RND_DATA,
    RND_LEN
  } rnd_sel_t;

  typedef struct packed {
    logic     load_init;
    logic     do_round;
    rnd_sel_t rnd_sel;
    logic     key_mix;
    logic     capture_in;
    logic     capture_ct;
    logic     capture_tag;
    logic     clear_out;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ ((x & TopBit) != 8'd0 ? GfReduce : 8'd0);
  endfunction

  function automatic logic [127:0] cipher_round(input logic [127:0] st, input logic [127:0] key);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = st[127 - 8 * i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = m[i];
    return res ^ key;
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8 * i +: 8] = x[56 - 8 * i +: 8];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rocca_s_aead_encrypt.sv
// Rocca-S AEAD encrypt top level: config registers, controller and datapath.
// Depends on rocca_pkg, rocca_ctrl, rocca_dp.
//   channel | signals                                   | direction
//   input   | in_valid, in_stall, command, data_word0-3, lengths | in
//   output  | out_valid, out_stall, result_kind, out_word0-3     | out
//   config  | cfg_we, cfg_index, cfg_data                       | in
// Associated-data and message items: one round in ST_SINGLE, then the result in ST_OUTPUT.
// Init: load, 16 rounds, key mix, then the result in ST_OUTPUT; finalize: 16 rounds,
// then the tag in ST_OUTPUT; one full state update per cycle in the round unit.
// One item is in flight at a time; in_stall is high until its result is taken,
// so out_stall holds the item in ST_OUTPUT and keeps new items out.
// rst is synchronous and clears the cipher state, config registers and control.
`timescale 1ns / 1ps
`default_nettype none
module rocca_s_aead_encrypt import rocca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [63:0] data_word0,
  input  wire logic [63:0] data_word1,
  input  wire logic [63:0] data_word2,
  input  wire logic [63:0] data_word3,
  input  wire logic [63:0] ad_bit_length,
  input  wire logic [63:0] msg_bit_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [63:0]      out_word0,
  output logic [63:0]      out_word1,
  output logic [63:0]      out_word2,
  output logic [63:0]      out_word3
);

  logic [63:0] cfg_reg [6];
  dp_cmd_t     dp_cmd;
  logic [255:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) cfg_reg[i] <= '0;
    end else if (cfg_we && cfg_index < NumCfgRegs) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  rocca_ctrl u_ctrl (
    .clk, .rst, .in_valid, .out_stall,
    .cmd(cmd_t'(command)), .in_stall, .out_valid, .dp_cmd
  );

  rocca_dp u_dp (
    .clk, .rst, .dp_cmd,
    .k0({cfg_reg[CfgKey0Hi], cfg_reg[CfgKey0Lo]}),
    .k1({cfg_reg[CfgKey1Hi], cfg_reg[CfgKey1Lo]}),
    .nonce({cfg_reg[CfgNonceHi], cfg_reg[CfgNonceLo]}),
    .data_in({data_word0, data_word1, data_word2, data_word3}),
    .ad_len(ad_bit_length), .msg_len(msg_bit_length),
    .kind(result_kind), .out_data
  );

  assign out_word0 = out_data[255:192];
  assign out_word1 = out_data[191:128];
  assign out_word2 = out_data[127:64];
  assign out_word3 = out_data[63:0];

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind != 2'd3) else $error("bad result kind");
`endif

endmodule
`default_nettype wire

// File: rtl/rocca_ctrl.sv
// Rocca-S controller: sequences init, data and finalize commands and the handshakes.
// Depends on rocca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rocca_ctrl import rocca_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    out_stall,
  input  wire cmd_t    cmd,
  output logic         in_stall,
  output logic         out_valid,
  output dp_cmd_t      dp_cmd
);

  state_t state, state_next;
  cmd_t   cmd_q;
  logic [RndCntW-1:0] rnd_cnt, rnd_cnt_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rnd_cnt <= '0;
      cmd_q   <= CMD_INIT;
    end else begin
      state   <= state_next;
      rnd_cnt <= rnd_cnt_next;
      if (accept) cmd_q <= cmd;
    end
  end

  always_comb begin
    state_next   = state;
    rnd_cnt_next = rnd_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rnd_cnt_next = '0;
          unique case (cmd)
            CMD_INIT: state_next = ST_INIT_LOAD;
            CMD_FIN:  state_next = ST_ROUNDS;
            default:  state_next = ST_SINGLE;
          endcase
        end
      end
      ST_INIT_LOAD: state_next = ST_ROUNDS;
      ST_ROUNDS: begin
        rnd_cnt_next = rnd_cnt + RndCntW'(1);
        if (rnd_cnt == RndCntW'(NumRounds - 1))
          state_next = (cmd_q == CMD_INIT) ? ST_KEY_MIX : ST_OUTPUT;
      end
      ST_KEY_MIX: state_next = ST_OUTPUT;
      ST_SINGLE:  state_next = ST_OUTPUT;
      ST_OUTPUT:  if (!out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd    = '0;
    dp_cmd.rnd_sel = RND_DATA;
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUTPUT);
    dp_cmd.capture_in = accept;
    unique case (state)
      ST_INIT_LOAD: dp_cmd.load_init = 1'b1;
      ST_ROUNDS: begin
        dp_cmd.do_round = 1'b1;
        dp_cmd.rnd_sel  = (cmd_q == CMD_INIT) ? RND_Z : RND_LEN;
        if (rnd_cnt == RndCntW'(NumRounds - 1)) begin
          dp_cmd.capture_tag = (cmd_q == CMD_FIN);
          dp_cmd.clear_out   = (cmd_q == CMD_INIT);
        end
      end
      ST_KEY_MIX: dp_cmd.key_mix = 1'b1;
      ST_SINGLE: begin
        dp_cmd.do_round   = 1'b1;
        dp_cmd.capture_ct = (cmd_q == CMD_MSG);
        dp_cmd.clear_out  = (cmd_q != CMD_MSG);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/rocca_dp.sv
// Rocca-S datapath: seven-word state, one full state update per cycle, output words.
// Depends on rocca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rocca_dp import rocca_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dp_cmd_t       dp_cmd,
  input  wire logic [127:0]  k0,
  input  wire logic [127:0]  k1,
  input  wire logic [127:0]  nonce,
  input  wire logic [255:0]  data_in,
  input  wire logic [63:0]   ad_len,
  input  wire logic [63:0]   msg_len,
  output logic [1:0]         kind,
  output logic [255:0]       out_data
);

  logic [127:0] s [7];
  logic [127:0] n [7];
  logic [127:0] x0, x1, la, lm, ra, rb, c0, c1;
  logic [1:0]   kind_next;

  always_ff @(posedge clk) begin
    if (dp_cmd.capture_in) begin
      x0 <= data_in[255:128];
      x1 <= data_in[127:0];
      la <= {bswap64(ad_len), 64'd0};
      lm <= {bswap64(msg_len), 64'd0};
    end
  end

  always_comb begin
    unique case (dp_cmd.rnd_sel)
      RND_Z:   begin ra = Z0; rb = Z1; end
      RND_LEN: begin ra = la; rb = lm; end
      default: begin ra = x0; rb = x1; end
    endcase
    n[0] = s[6] ^ s[1];
    n[1] = cipher_round(s[0], ra);
    n[2] = cipher_round(s[1], s[0]);
    n[3] = cipher_round(s[2], s[6]);
    n[4] = cipher_round(s[3], rb);
    n[5] = cipher_round(s[4], s[3]);
    n[6] = cipher_round(s[5], s[4]);
    c0 = cipher_round(s[3] ^ s[5], s[0]) ^ x0;
    c1 = cipher_round(s[4] ^ s[6], s[2]) ^ x1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) s[i] <= '0;
    end else if (dp_cmd.load_init) begin
      s[0] <= k1; s[1] <= nonce; s[2] <= Z0; s[3] <= k0;
      s[4] <= Z1; s[5] <= nonce ^ k1; s[6] <= '0;
    end else if (dp_cmd.do_round) begin
      for (int i = 0; i < 7; i++) s[i] <= n[i];
    end else if (dp_cmd.key_mix) begin
      s[0] <= s[0] ^ k0; s[1] <= s[1] ^ k0; s[2] <= s[2] ^ k1;
      s[3] <= s[3] ^ k0; s[4] <= s[4] ^ k0; s[5] <= s[5] ^ k1;
      s[6] <= s[6] ^ k1;
    end
  end

  assign kind_next = dp_cmd.capture_ct ? KIND_CIPHER :
                     dp_cmd.capture_tag ? KIND_TAG : KIND_ACK;

  always_ff @(posedge clk) begin
    if (dp_cmd.capture_ct) out_data <= {c0, c1};
    else if (dp_cmd.capture_tag)
      out_data <= {n[0] ^ n[1] ^ n[2] ^ n[3], n[4] ^ n[5] ^ n[6]};
    else if (dp_cmd.clear_out) out_data <= '0;
    if (dp_cmd.capture_ct || dp_cmd.capture_tag || dp_cmd.clear_out) kind <= kind_next;
  end

endmodule
`default_nettype wire

// File: verif/tb_rocca_s_aead_encrypt.sv
// Testbench for rocca_s_aead_encrypt: directed table then random command streams,
// each result checked against an in-bench Rocca-S predictor. Depends on rocca_pkg.
`timescale 1ns / 1ps
module tb_rocca_s_aead_encrypt;
  import rocca_pkg::*;

  localparam int RegKey0Hi = 0, RegKey0Lo = 1, RegKey1Hi = 2, RegKey1Lo = 3;
  localparam int RegNonceHi = 4, RegNonceLo = 5, RegBadLo = 6, RegBad = 7;
  localparam longint CycleLimit = 600000;

  typedef struct {
    logic [1:0] kind;
    logic [63:0] w [4];
  } aead_res_t;

  typedef struct {
    cmd_t cmd;
    logic [63:0] d [4];
    logic [63:0] adl;
    logic [63:0] msl;
    bit known;
    aead_res_t res;
  } aead_row_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] command = 0, result_kind;
  logic [63:0] data_word0 = 0, data_word1 = 0, data_word2 = 0, data_word3 = 0;
  logic [63:0] ad_bit_length = 0, msg_bit_length = 0;
  logic [63:0] out_word0, out_word1, out_word2, out_word3;

  rocca_s_aead_encrypt i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  logic [63:0] key_regs [6];
  logic [127:0] st [7];
  aead_res_t pending_q [$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  logic [7:0] sb [256];
  initial sb = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  function automatic logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] round_fn(logic [127:0] a, logic [127:0] k);
    logic [7:0] b [16];
    logic [7:0] sh [16];
    logic [127:0] r;
    logic [7:0] tot;
    for (int i = 0; i < 16; i++) b[i] = a[127 - 8*i -: 8];
    for (int row = 0; row < 4; row++)
      for (int col = 0; col < 4; col++)
        sh[row + 4*col] = sb[b[row + 4*((col + row) & 3)]];
    for (int col = 0; col < 4; col++) begin
      tot = sh[4*col] ^ sh[4*col+1] ^ sh[4*col+2] ^ sh[4*col+3];
      for (int j = 0; j < 4; j++)
        r[127 - 8*(4*col+j) -: 8] = sh[4*col+j] ^ tot
          ^ gmul2(sh[4*col+j] ^ sh[4*col+((j+1)&3)]);
    end
    return r ^ k;
  endfunction

  function automatic void state_round(logic [127:0] a, logic [127:0] b);
    logic [127:0] n [7];
    n[0] = st[6] ^ st[1];
    n[1] = round_fn(st[0], a);
    n[2] = round_fn(st[1], st[0]);
    n[3] = round_fn(st[2], st[6]);
    n[4] = round_fn(st[3], b);
    n[5] = round_fn(st[4], st[3]);
    n[6] = round_fn(st[5], st[4]);
    st = n;
  endfunction

  function automatic logic [63:0] rev_bytes(logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = x[56 - 8*i +: 8];
    return r;
  endfunction

  function automatic aead_res_t encrypt_step(aead_row_t it);
    aead_res_t r;
    logic [127:0] k0, k1, nn, x0, x1, la, lm, c0, c1;
    k0 = {key_regs[0], key_regs[1]};
    k1 = {key_regs[2], key_regs[3]};
    nn = {key_regs[4], key_regs[5]};
    x0 = {it.d[0], it.d[1]};
    x1 = {it.d[2], it.d[3]};
    c0 = '0;
    c1 = '0;
    r.kind = KIND_ACK;
    case (it.cmd)
      CMD_INIT: begin
        st = '{k1, nn, Z0, k0, Z1, nn ^ k1, 128'd0};
        for (int i = 0; i < 16; i++) state_round(Z0, Z1);
        st[0] ^= k0; st[1] ^= k0; st[2] ^= k1; st[3] ^= k0;
        st[4] ^= k0; st[5] ^= k1; st[6] ^= k1;
      end
      CMD_AD: state_round(x0, x1);
      CMD_MSG: begin
        c0 = round_fn(st[3] ^ st[5], st[0]) ^ x0;
        c1 = round_fn(st[4] ^ st[6], st[2]) ^ x1;
        state_round(x0, x1);
        r.kind = KIND_CIPHER;
      end
      default: begin
        la = {rev_bytes(it.adl), 64'd0};
        lm = {rev_bytes(it.msl), 64'd0};
        for (int i = 0; i < 16; i++) state_round(la, lm);
        c0 = st[0] ^ st[1] ^ st[2] ^ st[3];
        c1 = st[4] ^ st[5] ^ st[6];
        r.kind = KIND_TAG;
      end
    endcase
    r.w = '{c0[127:64], c0[63:0], c1[127:64], c1[63:0]};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver: stall at random, check each item taken
  always @(posedge clk) begin
    aead_res_t e;
    logic [63:0] got [4];
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{out_word0, out_word1, out_word2, out_word3};
      if (pending_q.size() == 0) begin
        $display("%0t unexpected item kind %0d", $time, result_kind);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (result_kind !== e.kind) begin
          $display("%0t kind exp %0d got %0d", $time, e.kind, result_kind);
          errors++;
        end
        for (int i = 0; i < 4; i++)
          if (got[i] !== e.w[i]) begin
            $display("%0t word%0d exp %h got %h", $time, i, e.w[i], got[i]);
            errors++;
          end
      end
    end
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < recv_idle);
  end

  task automatic write_reg(int idx, logic [63:0] v);
    cfg_we <= 1;
    cfg_index <= idx[2:0];
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx < 6) key_regs[idx] = v;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic send_item(aead_row_t it);
    aead_res_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= it.cmd;
    {data_word0, data_word1, data_word2, data_word3} <= {it.d[0], it.d[1], it.d[2], it.d[3]};
    ad_bit_length <= it.adl;
    msg_bit_length <= it.msl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = encrypt_step(it);
    if (it.known && (r.kind !== it.res.kind || r.w != it.res.w)) begin
      $display("%0t table row mismatch exp %0d got %0d", $time, it.res.kind, r.kind);
      errors++;
    end
    pending_q.push_back(r);
  endtask

  function automatic aead_row_t make_row(cmd_t c, logic [63:0] v, bit known, logic [1:0] k);
    aead_row_t it;
    it.cmd = c;
    it.d = '{v, v, v, v};
    it.adl = v;
    it.msl = ~v;
    it.known = known;
    it.res.kind = k;
    it.res.w = '{64'd0, 64'd0, 64'd0, 64'd0};
    return it;
  endfunction

  initial begin
    aead_row_t tbl [$];
    aead_row_t it;
    int n;
    key_regs = '{default: '0};
    st = '{default: '0};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // acknowledges carry zero words; rest via predictor
    tbl.push_back(make_row(CMD_AD, 64'd0, 1, KIND_ACK));
    tbl.push_back(make_row(CMD_MSG, 64'd0, 0, KIND_CIPHER));
    tbl.push_back(make_row(CMD_FIN, 64'd0, 0, KIND_TAG));
    tbl.push_back(make_row(CMD_INIT, '1, 1, KIND_ACK));
    tbl.push_back(make_row(CMD_AD, '1, 1, KIND_ACK));
    tbl.push_back(make_row(CMD_MSG, '1, 0, KIND_CIPHER));
    tbl.push_back(make_row(CMD_MSG, 64'h0123456789abcdef, 0, KIND_CIPHER));
    tbl.push_back(make_row(CMD_FIN, '1, 0, KIND_TAG));
    tbl.push_back(make_row(CMD_FIN, 64'h0000000000000100, 0, KIND_TAG));
    tbl.push_back(make_row(CMD_MSG, 64'h8000000000000001, 0, KIND_CIPHER));

    write_reg(RegBad, '1);
    write_reg(RegBadLo, '1);
    foreach (tbl[i]) send_item(tbl[i]);
    drain();

    foreach (tbl[i]) if (tbl[i].cmd == CMD_INIT) begin
      for (int r = 0; r < 6; r++) write_reg(r, '1);
      send_item(tbl[i]);
      send_item(tbl[i + 1]);
      send_item(tbl[i + 2]);
      drain();
      break;
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 67 : 0;
      recv_idle = (ph == 0) ? 67 : (ph == 1) ? 21 : 0;
      n = 0;
      while (n < 250) begin
        drain();
        for (int r = RegKey0Hi; r <= RegNonceLo; r++) write_reg(r, rand64());
        if ($urandom_range(0, 3) == 0) write_reg($urandom_range(RegBadLo, RegBad), rand64());
        // mostly well-formed: init, ad*, msg*, fin; sometimes shuffled
        for (int k = 0; k < 12 && n < 250; k++) begin
          it = make_row(CMD_AD, 0, 0, KIND_ACK);
          it.d = '{rand64(), rand64(), rand64(), rand64()};
          it.adl = rand64();
          it.msl = rand64();
          if ($urandom_range(0, 9) == 0) it.cmd = cmd_t'($urandom_range(0, 3));
          else if (k == 0) it.cmd = CMD_INIT;
          else if (k == 11) it.cmd = CMD_FIN;
          else if (k < 4) it.cmd = CMD_AD;
          else it.cmd = ($urandom_range(0, 5) == 0) ? CMD_FIN : CMD_MSG;
          send_item(it);
          n++;
          if (n == 120 && ph == 2) drain();
        end
      end
    end

    drain();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
